// File: hdl/tals_pkg.sv
// Shared package for the tilt-angle LED segment block.
// Holds widths, reset values, register indexes, control types and the arctangent table.
// No dependencies.
`default_nettype none

package tals_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_LEDS         = 64;
    localparam int MAX_SEGMENT      = 8;

    localparam int IN_W        = 16;
    localparam int SCALE_SHIFT = 16;
    localparam int VEC_W       = IN_W + SCALE_SHIFT + 3;
    localparam int LED_W       = 7;
    localparam int SEC_W       = 6;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 7;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - (LED_W + SEC_W + 2 * IN_W);
    localparam int ATAN_IDX_W  = 5;

    localparam logic [LED_W-1:0] LED_COUNT_RST = 7'd35;
    localparam logic [LEN_W-1:0] SEG_LEN_RST   = 4'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_LEDS
    } top_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCALE,
        PH_FIRST,
        PH_EMIT
    } seq_phase_t;

    typedef struct packed {
        logic             start;
        logic [LED_W-1:0] n;
        logic [LEN_W-1:0] len;
    } seg_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic done;
    } seg_stat_t;

    // atan(2^-i) in units of 1/2^32 turn, truncated
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051D;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2F9;
            5'd15:   r = 32'h0000_517C;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A2F;
            5'd19:   r = 32'h0000_0517;
            5'd20:   r = 32'h0000_028B;
            5'd21:   r = 32'h0000_0145;
            5'd22:   r = 32'h0000_00A2;
            5'd23:   r = 32'h0000_0051;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tilt_angle_led_segment.sv
// Top level of the tilt-angle LED segment block: stream ports, config registers, peak tracking.
// Instantiates tals_cordic and tals_ledseq. Depends on tals_pkg.
//
// One accelerometer sample (x, y) in, one LED transfer out per lit LED. The angle is found by
// an iterative CORDIC that does one micro-rotation per cycle. A sample occupies the block
// until its last LED transfer is taken, also while the result side holds m_tready low.
// s_tready is high only while the block is idle. Every result carries the x and y readings
// of greatest magnitude seen since reset, already updated by the current sample; the last
// LED of a sample is marked with m_tlast. led_count and the segment length are written through
// the cfg port; the user must write them only while idle, which the block does not enforce;
// zero reads as one and values above MAX_LEDS or MAX_SEGMENT are clamped.
`default_nettype none

module tilt_angle_led_segment #(
    parameter int ANGLE_BITS   = tals_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = tals_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // [15:0] accel_x, [31:16] accel_y
    input  wire logic [tals_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [6:0] led_number, [12:7] sector_index, [28:13] peak_x, [44:29] peak_y, [47:45] zero
    output logic [tals_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tals_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tals_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IW = tals_pkg::IN_W;
    localparam int LW = tals_pkg::LED_W;
    localparam int NW = tals_pkg::LEN_W;
    localparam logic [31:0] MAX_LEDS_U    = 32'(tals_pkg::MAX_LEDS);
    localparam logic [31:0] MAX_SEGMENT_U = 32'(tals_pkg::MAX_SEGMENT);

    tals_pkg::top_state_t state_reg, state_next;
    logic [LW-1:0]        led_count_reg, led_count_next;
    logic [NW-1:0]        seg_len_reg, seg_len_next;
    logic signed [IW-1:0] peak_x_reg, peak_x_next;
    logic signed [IW-1:0] peak_y_reg, peak_y_next;

    logic signed [IW-1:0] in_x, in_y;
    logic [IW:0]          abs_x, abs_y, abs_px, abs_py;
    logic                 s_xfer;
    logic [LW-1:0]        n_eff;
    logic [NW-1:0]        len_eff;

    logic                  cordic_done;
    logic [ANGLE_BITS-1:0] angle;
    tals_pkg::seg_ctl_t    seg_ctl;
    tals_pkg::seg_stat_t   seg_stat;
    logic [LW-1:0]         led_number, sector;

    function automatic logic [IW:0] mag(input logic signed [IW-1:0] v);
        logic signed [IW:0] e;
        e = {v[IW-1], v};
        return v[IW-1] ? (IW + 1)'(-e) : (IW + 1)'(e);
    endfunction

    assign in_x   = s_tdata[IW-1:0];
    assign in_y   = s_tdata[2*IW-1:IW];
    assign abs_x  = mag(in_x);
    assign abs_y  = mag(in_y);
    assign abs_px = mag(peak_x_reg);
    assign abs_py = mag(peak_y_reg);

    assign s_tready = (state_reg == tals_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        if (led_count_reg == '0) begin
            n_eff = LW'(1);
        end else if (32'(led_count_reg) > MAX_LEDS_U) begin
            n_eff = LW'(tals_pkg::MAX_LEDS);
        end else begin
            n_eff = led_count_reg;
        end
        if (seg_len_reg == '0) begin
            len_eff = NW'(1);
        end else if (32'(seg_len_reg) > MAX_SEGMENT_U) begin
            len_eff = NW'(tals_pkg::MAX_SEGMENT);
        end else begin
            len_eff = seg_len_reg;
        end
    end

    always_comb begin
        led_count_next = led_count_reg;
        seg_len_next   = seg_len_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tals_pkg::REG_LED_COUNT: led_count_next = cfg_data[LW-1:0];
                tals_pkg::REG_SEG_LEN:   seg_len_next   = cfg_data[NW-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        peak_x_next = peak_x_reg;
        peak_y_next = peak_y_reg;
        case (state_reg)
            tals_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (abs_x > abs_px) peak_x_next = in_x;
                    if (abs_y > abs_py) peak_y_next = in_y;
                    state_next = tals_pkg::ST_ANGLE;
                end
            end
            tals_pkg::ST_ANGLE: begin
                if (cordic_done) state_next = tals_pkg::ST_LEDS;
            end
            tals_pkg::ST_LEDS: begin
                if (seg_stat.done) state_next = tals_pkg::ST_IDLE;
            end
            default: begin
                state_next = tals_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tals_pkg::ST_IDLE;
            led_count_reg <= tals_pkg::LED_COUNT_RST;
            seg_len_reg   <= tals_pkg::SEG_LEN_RST;
            peak_x_reg    <= '0;
            peak_y_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            led_count_reg <= led_count_next;
            seg_len_reg   <= seg_len_next;
            peak_x_reg    <= peak_x_next;
            peak_y_reg    <= peak_y_next;
        end
    end

    tals_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_xfer),
        .x_in    (in_x),
        .y_in    (in_y),
        .done    (cordic_done),
        .angle   (angle)
    );

    assign seg_ctl.start = cordic_done;
    assign seg_ctl.n     = n_eff;
    assign seg_ctl.len   = len_eff;

    tals_ledseq #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_ledseq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (seg_ctl),
        .angle      (angle),
        .out_ready  (m_tready),
        .stat       (seg_stat),
        .led_number (led_number),
        .sector     (sector)
    );

    assign m_tvalid = seg_stat.valid;
    assign m_tlast  = seg_stat.last;
    assign m_tdata  = {{tals_pkg::M_PAD_W{1'b0}}, peak_y_reg, peak_x_reg,
                       sector[tals_pkg::SEC_W-1:0], led_number};

endmodule

`default_nettype wire

// File: hdl/tals_cordic.sv
// Iterative CORDIC in vectoring mode: one micro-rotation per cycle on a shared add/shift unit.
// Produces the atan2 angle in 1/2^ANGLE_BITS turn. Depends on tals_pkg.
`default_nettype none

module tals_cordic #(
    parameter int ANGLE_BITS   = tals_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = tals_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [tals_pkg::IN_W-1:0]  x_in,
    input  wire logic signed [tals_pkg::IN_W-1:0]  y_in,
    output logic                                   done,
    output logic [ANGLE_BITS-1:0]                  angle
);

    localparam int W      = tals_pkg::VEC_W;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [31:0] HALF_LSB = 32'(1) << (31 - ANGLE_BITS);

    logic                  run_reg, run_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic signed [W-1:0]   x_reg, x_next;
    logic signed [W-1:0]   y_reg, y_next;
    logic [31:0]           z_reg, z_next;
    logic                  zero_reg, zero_next;
    logic [ANGLE_BITS-1:0] angle_reg, angle_next;

    logic signed [W-1:0]   x_ext, y_ext, dx, dy;
    logic [31:0]           phase, atan_val;

    assign x_ext    = {{(W - 32){x_in[tals_pkg::IN_W-1]}}, x_in, 16'h0000};
    assign y_ext    = {{(W - 32){y_in[tals_pkg::IN_W-1]}}, y_in, 16'h0000};
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = tals_pkg::atan_turn(tals_pkg::ATAN_IDX_W'(step_reg));
    assign phase    = z_reg + HALF_LSB;

    always_comb begin
        run_next   = run_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        angle_next = angle_reg;
        if (start) begin
            run_next  = 1'b1;
            step_next = '0;
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in[tals_pkg::IN_W-1]) begin
                x_next = -x_ext;
                y_next = -y_ext;
                z_next = 32'h8000_0000;
            end else begin
                x_next = x_ext;
                y_next = y_ext;
                z_next = 32'h0000_0000;
            end
        end else if (run_reg) begin
            if (!y_reg[W-1]) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end
            if (step_reg == LAST_STEP) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end else if (fin_reg) begin
            angle_next = zero_reg ? '0 : phase[31 -: ANGLE_BITS];
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

// File: hdl/tals_ledseq.sv
// LED segment sequencer: scales the angle to a sector, then steps through the lit LEDs.
// Registers led number and sector; last flag is combinational. Depends on tals_pkg.
`default_nettype none

module tals_ledseq #(
    parameter int ANGLE_BITS = tals_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tals_pkg::seg_ctl_t          ctl,
    input  wire logic [ANGLE_BITS-1:0]       angle,
    input  wire logic                        out_ready,
    output tals_pkg::seg_stat_t              stat,
    output logic [tals_pkg::LED_W-1:0]       led_number,
    output logic [tals_pkg::LED_W-1:0]       sector
);

    localparam int LW = tals_pkg::LED_W;
    localparam int PW = ANGLE_BITS + LW;

    tals_pkg::seq_phase_t       phase_reg, phase_next;
    logic [LW-1:0]              sector_reg, sector_next;
    logic [LW-1:0]              led_reg, led_next;
    logic [tals_pkg::LEN_W-1:0] k_reg, k_next;
    logic [PW-1:0]              prod;
    logic                       is_last;

    assign prod    = PW'(angle) * PW'(ctl.n);
    assign is_last = (k_reg == (ctl.len - 1'b1));

    always_comb begin
        phase_next  = phase_reg;
        sector_next = sector_reg;
        led_next    = led_reg;
        k_next      = k_reg;
        stat.valid  = 1'b0;
        stat.last   = is_last;
        stat.done   = 1'b0;
        case (phase_reg)
            tals_pkg::PH_IDLE: begin
                if (ctl.start) begin
                    phase_next = tals_pkg::PH_SCALE;
                end
            end
            tals_pkg::PH_SCALE: begin
                sector_next = prod[ANGLE_BITS +: LW];
                phase_next  = tals_pkg::PH_FIRST;
            end
            tals_pkg::PH_FIRST: begin
                led_next   = (sector_reg == '0) ? ctl.n : sector_reg;
                k_next     = '0;
                phase_next = tals_pkg::PH_EMIT;
            end
            tals_pkg::PH_EMIT: begin
                stat.valid = 1'b1;
                if (out_ready) begin
                    if (is_last) begin
                        stat.done  = 1'b1;
                        phase_next = tals_pkg::PH_IDLE;
                    end else begin
                        k_next   = k_reg + 1'b1;
                        led_next = (led_reg == ctl.n) ? LW'(1) : led_reg + 1'b1;
                    end
                end
            end
            default: begin
                phase_next = tals_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tals_pkg::PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        sector_reg <= sector_next;
        led_reg    <= led_next;
        k_reg      <= k_next;
    end

    assign led_number = led_reg;
    assign sector     = sector_reg;

endmodule

`default_nettype wire
